>>> rtl/core/mtt_pkg.sv
// Package for the timer table: request/result structs, opcodes, result kinds,
// sequencer states and table entry layout.
// No dependencies; imported by multi_timer_table and mtt_checker.
package mtt_pkg;

    localparam int DEF_MAX_TIMERS = 16;
    localparam int RESULT_CAP     = 16;
    localparam int ID_W           = 32;
    localparam int TIME_W         = 64;
    localparam int PERIOD_W       = 31;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ONESHOT  = 2'd1,
        OP_PERIODIC = 2'd2,
        OP_CANCEL   = 2'd3
    } t_op;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_REG    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_FIRE   = 2'd2
    } t_kind;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] interval;
        logic [31:0]        cancel_id;
    } t_in_req;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] timer_id;
        logic        ok;
        logic        last;
    } t_out_res;

    // One table entry as held in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   deadline;
        logic [PERIOD_W-1:0] period;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_COMMIT,
        ST_FIRE,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/core/multi_timer_table.sv
// Timer table top level: slot memory, valid bits and the scan sequencer.
// Depends on mtt_pkg.
//
// Usage: one request per input item on i_in_valid/o_in_stall with payload
// i_in_data (tick, register one-shot, register periodic, cancel). Results
// leave on o_out_valid/i_out_stall with payload o_out_data; last marks the
// final result of a request. A tick with nothing due gives no result.
// Every request is worked by one sequencer that walks the slot memory one
// entry a cycle (one read port, registered read data), so cost follows
// MAX_TIMERS (M):
//   cancel            : one full scan, then the result register
//   register          : one full scan, then a pick step per live id skipped
//                       (at most M - 1); a full table answers after the scan,
//                       a rejected period answers without any scan
//   tick              : one full scan per fired timer, and
//                       at most 16 fires per tick; one scan when none are due
// The input is stalled while a request is being worked. Results sit in an
// output register, so a new request is taken while the last result is still
// stalled; an earlier result of the same tick holds the sequencer until it
// is taken. Reset clears time to 0, the id counter to 1 and all valid bits
// at once; no clearing pass is needed.
module multi_timer_table
    import mtt_pkg::*;
#(
    parameter int MAX_TIMERS = DEF_MAX_TIMERS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_data
);

    localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int FW = $clog2(RESULT_CAP + 1);
    localparam logic [CW-1:0] M_CNT = CW'(MAX_TIMERS);

    function automatic logic [ID_W-1:0] f_bump(input logic [ID_W-1:0] v);
        logic [ID_W-1:0] s;
        s = v + ID_W'(1);
        return (s == '0) ? ID_W'(1) : s;
    endfunction

    // Position of id in the id sequence starting at c, skipping 0
    function automatic logic [ID_W-1:0] f_seq_pos(input logic [ID_W-1:0] id,
                                                  input logic [ID_W-1:0] c);
        logic [ID_W:0] diff;
        diff = {1'b0, id} - {1'b0, c};
        return diff[ID_W] ? (diff[ID_W-1:0] - ID_W'(1)) : diff[ID_W-1:0];
    endfunction

    t_state              r_state, n_state;
    t_in_req             r_req;
    t_out_res            r_res, r_out_data;
    logic                r_out_valid;
    logic [TIME_W-1:0]   r_time;
    logic [ID_W-1:0]     r_id_ctr, r_cand;
    logic [MAX_TIMERS-1:0] r_valid, r_fired, r_bitmap;
    logic [CW-1:0]       r_idx;
    logic                r_pend;
    logic [AW-1:0]       r_pidx;
    logic                r_free_found;
    logic [AW-1:0]       r_free_idx;
    logic                r_hit;
    logic                r_best_found, r_due_more;
    logic [AW-1:0]       r_best_idx;
    t_entry              r_best;
    logic [FW-1:0]       r_nfired;
    t_entry              mem [MAX_TIMERS];
    t_entry              r_rd;

    logic                accept, issue, scan_done, out_load, pick_hit;
    logic                in_positive, positive, due, best_last;
    logic [TIME_W-1:0]   delay, add_a, add_b, add_sum;
    logic [PERIOD_W-1:0] new_period;
    logic [ID_W-1:0]     seq_pos;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    t_entry              mem_wdata;

    // Handshake and sequencing strobes
    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign issue       = (r_state == ST_SCAN) && (r_idx != M_CNT);
    assign scan_done   = (r_state == ST_SCAN) && (r_idx == M_CNT) && !r_pend;
    assign out_load    = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    assign pick_hit    = r_bitmap[r_idx[AW-1:0]];
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Request decode
    assign in_positive = (i_in_data.interval != '0) && !i_in_data.interval[31];
    assign positive    = (r_req.interval != '0) && !r_req.interval[31];
    assign delay       = positive ? {32'd0, r_req.interval} : TIME_W'(1);
    assign new_period  = (r_req.op == OP_PERIODIC) ? r_req.interval[PERIOD_W-1:0] : '0;

    // Per-entry scan terms
    assign seq_pos   = f_seq_pos(r_rd.id, r_cand);
    assign due       = r_pend && r_valid[r_pidx] && !r_fired[r_pidx]
                       && (r_rd.deadline <= r_time);
    assign best_last = !r_due_more || (r_nfired == FW'(RESULT_CAP - 1));

    // Shared deadline adder: new timer deadline or periodic re-arm
    always_comb begin
        if (r_state == ST_COMMIT) begin
            add_a = r_time;
            add_b = delay;
        end else begin
            add_a = r_best.deadline;
            add_b = {{(TIME_W-PERIOD_W){1'b0}}, r_best.period};
        end
        add_sum = add_a + add_b;
    end

    // Slot memory write port
    always_comb begin
        mem_we             = 1'b0;
        mem_waddr          = r_free_idx;
        mem_wdata.id       = r_cand;
        mem_wdata.deadline = add_sum;
        mem_wdata.period   = new_period;
        if (r_state == ST_COMMIT) begin
            mem_we = 1'b1;
        end else if ((r_state == ST_FIRE) && r_best_found && (r_best.period != '0)) begin
            mem_we           = 1'b1;
            mem_waddr        = r_best_idx;
            mem_wdata.id     = r_best.id;
            mem_wdata.period = r_best.period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((i_in_data.op == OP_PERIODIC) && !in_positive) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    unique case (r_req.op)
                        OP_TICK:   n_state = ST_FIRE;
                        OP_CANCEL: n_state = ST_EMIT;
                        OP_ONESHOT, OP_PERIODIC: begin
                            n_state = r_free_found ? ST_PICK : ST_EMIT;
                        end
                    endcase
                end
            end
            ST_PICK: begin
                if (!pick_hit) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: n_state = ST_EMIT;
            ST_FIRE:   n_state = r_best_found ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (out_load) begin
                    n_state = r_res.last ? ST_IDLE : ST_SCAN;
                end
            end
        endcase
    end

    // Control state: time, id counter, valid bits, scan flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_id_ctr     <= ID_W'(1);
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_free_found <= 1'b0;
            r_hit        <= 1'b0;
            r_best_found <= 1'b0;
            r_due_more   <= 1'b0;
            r_fired      <= '0;
            r_nfired     <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_idx        <= '0;
                        r_pend       <= 1'b0;
                        r_free_found <= 1'b0;
                        r_hit        <= 1'b0;
                        r_best_found <= 1'b0;
                        r_due_more   <= 1'b0;
                        r_fired      <= '0;
                        r_nfired     <= '0;
                        if (i_in_data.op == OP_TICK) begin
                            r_time <= r_time + TIME_W'(1);
                        end
                    end
                end
                ST_SCAN: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (scan_done) begin
                        r_idx <= '0;
                    end
                    if (r_pend) begin
                        unique case (r_req.op)
                            OP_TICK: begin
                                if (due) begin
                                    if (r_best_found) begin
                                        r_due_more <= 1'b1;
                                    end
                                    r_best_found <= 1'b1;
                                end
                            end
                            OP_CANCEL: begin
                                if (r_valid[r_pidx] && (r_req.cancel_id != '0)
                                    && (r_rd.id == r_req.cancel_id)) begin
                                    r_valid[r_pidx] <= 1'b0;
                                    r_hit           <= 1'b1;
                                end
                            end
                            OP_ONESHOT, OP_PERIODIC: begin
                                if (!r_valid[r_pidx]) begin
                                    r_free_found <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                ST_PICK: begin
                    if (pick_hit) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_COMMIT: begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_id_ctr            <= f_bump(r_cand);
                end
                ST_FIRE: begin
                    if (r_best_found) begin
                        if (r_best.period == '0) begin
                            r_valid[r_best_idx] <= 1'b0;
                        end
                        r_fired[r_best_idx] <= 1'b1;
                        r_nfired            <= r_nfired + FW'(1);
                    end
                end
                ST_EMIT: begin
                    // next fire round rescans the table
                    if (out_load && !r_res.last) begin
                        r_idx        <= '0;
                        r_pend       <= 1'b0;
                        r_best_found <= 1'b0;
                        r_due_more   <= 1'b0;
                    end
                end
            endcase
        end
    end

    // Payload registers: request, candidates, pending result
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pidx <= r_idx[AW-1:0];
        end
        if (out_load) begin
            r_out_data <= r_res;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_req          <= i_in_data;
                    r_cand         <= r_id_ctr;
                    r_bitmap       <= '0;
                    // preset to the failed-registration answer
                    r_res.kind     <= KIND_REG;
                    r_res.timer_id <= '0;
                    r_res.ok       <= 1'b0;
                    r_res.last     <= 1'b1;
                end
            end
            ST_SCAN: begin
                if (r_pend) begin
                    unique case (r_req.op)
                        OP_TICK: begin
                            if (due && (!r_best_found || (r_rd.id < r_best.id))) begin
                                r_best     <= r_rd;
                                r_best_idx <= r_pidx;
                            end
                        end
                        OP_CANCEL: ;
                        OP_ONESHOT, OP_PERIODIC: begin
                            if (r_valid[r_pidx] && (seq_pos < ID_W'(MAX_TIMERS))) begin
                                r_bitmap[seq_pos[AW-1:0]] <= 1'b1;
                            end
                            if (!r_valid[r_pidx] && !r_free_found) begin
                                r_free_idx <= r_pidx;
                            end
                        end
                    endcase
                end
                if (scan_done && (r_req.op == OP_CANCEL)) begin
                    r_res.kind     <= KIND_CANCEL;
                    r_res.timer_id <= r_req.cancel_id;
                    r_res.ok       <= r_hit;
                    r_res.last     <= 1'b1;
                end
            end
            ST_PICK: begin
                // skip ids held by live entries
                if (pick_hit) begin
                    r_cand <= f_bump(r_cand);
                end
            end
            ST_COMMIT: begin
                r_res.kind     <= KIND_REG;
                r_res.timer_id <= r_cand;
                r_res.ok       <= 1'b1;
                r_res.last     <= 1'b1;
            end
            ST_FIRE: begin
                r_res.kind     <= KIND_FIRE;
                r_res.timer_id <= r_best.id;
                r_res.ok       <= 1'b1;
                r_res.last     <= best_last;
            end
            ST_EMIT: ;
        endcase
    end

endmodule

>>> rtl/core/mtt_checker.sv
// Port-level checks for multi_timer_table, bound to the top level.
// Depends on mtt_pkg.
module mtt_checker
    import mtt_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_res o_out_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Register and cancel answers are always the only result of their request
    a_answer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_REG || o_out_data.kind == KIND_CANCEL)
        |-> o_out_data.last)
        else $error("answer without last");

    // Registration succeeds exactly when a non-zero id is handed out
    a_reg_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_REG)
        |-> (o_out_data.ok == (o_out_data.timer_id != '0)))
        else $error("register answer ok and id disagree");

    // A fired timer carries a live id
    a_fire_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_FIRE)
        |-> o_out_data.ok && (o_out_data.timer_id != '0))
        else $error("fire with zero id or ok low");

    // Every taken request makes the block busy in the following cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken without busy cycle");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (.*);
